>>> rtl/core/bole_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and command/status structs of the ordered list engine.
package bole_pkg;

  localparam int IN_W  = 40;
  localparam int OUT_W = 48;

  typedef logic [IN_W-1:0]   in_bus_t;
  typedef logic [OUT_W-1:0]  out_bus_t;
  typedef logic [3:0]        action_t;
  typedef logic [3:0]        pos_t;
  typedef logic signed [31:0] val_t;
  typedef logic [1:0]        status_t;
  typedef logic [3:0]        len_t;
  typedef logic [1:0]        sel_t;

  // request actions
  localparam action_t ACT_INS_FRONT = 4'd0;
  localparam action_t ACT_INS_END   = 4'd1;
  localparam action_t ACT_INS_AT    = 4'd2;
  localparam action_t ACT_DEL_AT    = 4'd3;
  localparam action_t ACT_READ      = 4'd4;
  localparam action_t ACT_REPLACE   = 4'd5;
  localparam action_t ACT_SEARCH    = 4'd6;
  localparam action_t ACT_DEL_KEY   = 4'd7;
  localparam action_t ACT_CLEAR     = 4'd8;

  // result status
  localparam status_t ST_OK     = 2'd0;
  localparam status_t ST_FULL   = 2'd1;
  localparam status_t ST_BADPOS = 2'd2;
  localparam status_t ST_NOKEY  = 2'd3;

  // walk index load sources
  localparam sel_t IDX_CNT_M1 = 2'd0;
  localparam sel_t IDX_POS    = 2'd1;
  localparam sel_t IDX_ZERO   = 2'd2;
  localparam sel_t IDX_NEXT   = 2'd3;

  // insert/replace point load sources
  localparam sel_t PT_ZERO = 2'd0;
  localparam sel_t PT_CNT  = 2'd1;
  localparam sel_t PT_POS  = 2'd2;

  typedef struct packed {
    logic    cap;
    logic    idx_ld;
    sel_t    idx_sel;
    logic    idx_inc;
    logic    idx_dec;
    logic    pt_ld;
    sel_t    pt_sel;
    logic    rd;
    logic    mv_wb;
    logic    mv_up;
    logic    wr_val;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    cnt_clr;
    logic    st_ld;
    status_t st;
    logic    dat_ld;
    logic    fnd_set;
    logic    res_ld;
  } cmd_t;

  typedef struct packed {
    action_t act;
    logic    pos_gt_cnt;
    logic    pos_ge_cnt;
    logic    cnt_zero;
    logic    cnt_full;
    logic    idx_eq_pt;
    logic    idx_lt_cnt;
    logic    rd_vld;
    logic    match;
    logic    out_free;
  } sts_t;

endpackage

>>> rtl/core/bole_dp.sv
`timescale 1ns / 1ps
// Datapath: entry memory, count, walk index, pending result and output register.
module bole_dp #(
  parameter int CAPACITY = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  bole_pkg::in_bus_t  in_tdata,
  input  bole_pkg::cmd_t     cmd,
  output bole_pkg::sts_t     sts,
  output logic               out_tvalid,
  input  logic               out_tready,
  output bole_pkg::out_bus_t out_tdata
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int MW = (CW > 4) ? CW : 4;

  typedef logic [AW-1:0] addr_t;
  typedef logic [CW-1:0] cnt_t;
  typedef logic [MW-1:0] cmp_t;

  bole_pkg::val_t    mem [CAPACITY];

  bole_pkg::action_t act_r;
  bole_pkg::pos_t    pos_r;
  bole_pkg::val_t    val_r;
  cnt_t              count_r;
  cnt_t              count_nxt;
  cnt_t              idx_r;
  cnt_t              idx_nxt;
  addr_t             pt_r;
  addr_t             rd_addr_r;
  bole_pkg::val_t    rd_data_r;
  logic              rd_vld_r;

  bole_pkg::status_t st_r;
  bole_pkg::val_t    dat_r;
  logic              fnd_r;

  logic              out_vld_r;
  bole_pkg::status_t o_st_r;
  bole_pkg::val_t    o_dat_r;
  logic              o_fnd_r;
  bole_pkg::len_t    o_len_r;
  logic              o_full_r;
  logic              o_empty_r;

  logic              we;
  addr_t             wa;
  bole_pkg::val_t    wd;
  addr_t             ra;

  assign ra = idx_r[AW-1:0];
  assign we = cmd.wr_val | (cmd.mv_wb & rd_vld_r);
  assign wd = cmd.wr_val ? val_r : rd_data_r;

  always_comb begin
    if (cmd.wr_val) begin
      wa = pt_r;
    end else if (cmd.mv_up) begin
      wa = rd_addr_r + addr_t'(1);
    end else begin
      wa = rd_addr_r - addr_t'(1);
    end
  end

  // entry store, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (cmd.rd) begin
      rd_data_r <= mem[ra];
      rd_addr_r <= ra;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.rd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      act_r <= in_tdata[3:0];
      pos_r <= in_tdata[7:4];
      val_r <= in_tdata[39:8];
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.cnt_clr) begin
      count_nxt = '0;
    end else if (cmd.cnt_inc) begin
      count_nxt = count_r + cnt_t'(1);
    end else if (cmd.cnt_dec) begin
      count_nxt = count_r - cnt_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.idx_ld) begin
      unique case (cmd.idx_sel)
        bole_pkg::IDX_CNT_M1: idx_nxt = count_r - cnt_t'(1);
        bole_pkg::IDX_POS:    idx_nxt = cnt_t'(pos_r);
        bole_pkg::IDX_ZERO:   idx_nxt = '0;
        bole_pkg::IDX_NEXT:   idx_nxt = cnt_t'(rd_addr_r) + cnt_t'(1);
        default:              idx_nxt = idx_r;
      endcase
    end else if (cmd.idx_inc) begin
      idx_nxt = idx_r + cnt_t'(1);
    end else if (cmd.idx_dec) begin
      idx_nxt = idx_r - cnt_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (cmd.pt_ld) begin
      unique case (cmd.pt_sel)
        bole_pkg::PT_ZERO: pt_r <= '0;
        bole_pkg::PT_CNT:  pt_r <= addr_t'(count_r);
        default:           pt_r <= addr_t'(pos_r);
      endcase
    end
  end

  // pending result, built up while the request is worked
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      st_r  <= bole_pkg::ST_OK;
      dat_r <= '0;
      fnd_r <= 1'b0;
    end else begin
      if (cmd.st_ld) begin
        st_r <= cmd.st;
      end
      if (cmd.dat_ld) begin
        dat_r <= rd_data_r;
      end
      if (cmd.fnd_set) begin
        fnd_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd.res_ld) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_ld) begin
      o_st_r    <= st_r;
      o_dat_r   <= dat_r;
      o_fnd_r   <= fnd_r;
      o_len_r   <= bole_pkg::len_t'(count_r);
      o_full_r  <= (count_r == cnt_t'(CAPACITY));
      o_empty_r <= (count_r == '0);
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = bole_pkg::out_bus_t'({o_empty_r, o_full_r, o_len_r, o_fnd_r,
                                            o_dat_r, o_st_r});

  always_comb begin
    sts.act        = act_r;
    sts.pos_gt_cnt = cmp_t'(pos_r) > cmp_t'(count_r);
    sts.pos_ge_cnt = cmp_t'(pos_r) >= cmp_t'(count_r);
    sts.cnt_zero   = (count_r == '0);
    sts.cnt_full   = (count_r == cnt_t'(CAPACITY));
    sts.idx_eq_pt  = (idx_r == cnt_t'(pt_r));
    sts.idx_lt_cnt = (idx_r < count_r);
    sts.rd_vld     = rd_vld_r;
    sts.match      = (rd_data_r == val_r);
    sts.out_free   = !out_vld_r || out_tready;
  end

endmodule

>>> rtl/core/bole_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences each request over the datapath's memory walk.
module bole_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  bole_pkg::sts_t sts,
  output bole_pkg::cmd_t cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DEC   = 4'd1;
  localparam logic [3:0] S_SHUP  = 4'd2;
  localparam logic [3:0] S_DRAIN = 4'd3;
  localparam logic [3:0] S_WR    = 4'd4;
  localparam logic [3:0] S_RD    = 4'd5;
  localparam logic [3:0] S_RGET  = 4'd6;
  localparam logic [3:0] S_DSH   = 4'd7;
  localparam logic [3:0] S_DEND  = 4'd8;
  localparam logic [3:0] S_SCAN  = 4'd9;
  localparam logic [3:0] S_FIN   = 4'd10;

  logic [3:0] state_r;
  logic [3:0] state_nxt;
  logic       at_point;

  assign in_tready = (state_r == S_IDLE);

  // insert lands at the current end, so nothing has to move up
  assign at_point = (sts.act == bole_pkg::ACT_INS_END) ||
                    ((sts.act == bole_pkg::ACT_INS_FRONT) && sts.cnt_zero) ||
                    ((sts.act == bole_pkg::ACT_INS_AT) && sts.pos_ge_cnt && !sts.pos_gt_cnt);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.cap   = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        unique case (sts.act)
          bole_pkg::ACT_INS_FRONT, bole_pkg::ACT_INS_END, bole_pkg::ACT_INS_AT: begin
            priority if (sts.cnt_full) begin
              cmd.st_ld = 1'b1;
              cmd.st    = bole_pkg::ST_FULL;
              state_nxt = S_FIN;
            end else if (sts.act == bole_pkg::ACT_INS_AT && sts.pos_gt_cnt) begin
              cmd.st_ld = 1'b1;
              cmd.st    = bole_pkg::ST_BADPOS;
              state_nxt = S_FIN;
            end else begin
              cmd.pt_ld   = 1'b1;
              cmd.pt_sel  = (sts.act == bole_pkg::ACT_INS_FRONT) ? bole_pkg::PT_ZERO :
                            (sts.act == bole_pkg::ACT_INS_END)   ? bole_pkg::PT_CNT  :
                                                                    bole_pkg::PT_POS;
              cmd.idx_ld  = 1'b1;
              cmd.idx_sel = bole_pkg::IDX_CNT_M1;
              state_nxt   = at_point ? S_WR : S_SHUP;
            end
          end
          bole_pkg::ACT_DEL_AT, bole_pkg::ACT_READ, bole_pkg::ACT_REPLACE: begin
            if (sts.pos_ge_cnt) begin
              cmd.st_ld = 1'b1;
              cmd.st    = bole_pkg::ST_BADPOS;
              state_nxt = S_FIN;
            end else begin
              cmd.pt_ld   = 1'b1;
              cmd.pt_sel  = bole_pkg::PT_POS;
              cmd.idx_ld  = 1'b1;
              cmd.idx_sel = bole_pkg::IDX_POS;
              state_nxt   = (sts.act == bole_pkg::ACT_REPLACE) ? S_WR : S_RD;
            end
          end
          bole_pkg::ACT_SEARCH, bole_pkg::ACT_DEL_KEY: begin
            if (sts.cnt_zero) begin
              if (sts.act == bole_pkg::ACT_DEL_KEY) begin
                cmd.st_ld = 1'b1;
                cmd.st    = bole_pkg::ST_NOKEY;
              end
              state_nxt = S_FIN;
            end else begin
              cmd.idx_ld  = 1'b1;
              cmd.idx_sel = bole_pkg::IDX_ZERO;
              state_nxt   = S_SCAN;
            end
          end
          bole_pkg::ACT_CLEAR: begin
            cmd.cnt_clr = 1'b1;
            state_nxt   = S_FIN;
          end
          default: begin
            state_nxt = S_FIN;
          end
        endcase
      end
      // read downward from the last entry, each beat written one place up
      S_SHUP: begin
        cmd.rd      = 1'b1;
        cmd.idx_dec = 1'b1;
        cmd.mv_wb   = 1'b1;
        cmd.mv_up   = 1'b1;
        if (sts.idx_eq_pt) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        cmd.mv_wb = 1'b1;
        cmd.mv_up = 1'b1;
        state_nxt = S_WR;
      end
      S_WR: begin
        cmd.wr_val  = 1'b1;
        cmd.cnt_inc = (sts.act != bole_pkg::ACT_REPLACE);
        state_nxt   = S_FIN;
      end
      S_RD: begin
        cmd.rd      = 1'b1;
        cmd.idx_inc = 1'b1;
        state_nxt   = S_RGET;
      end
      S_RGET: begin
        cmd.dat_ld = 1'b1;
        priority if (sts.act == bole_pkg::ACT_READ) begin
          state_nxt = S_FIN;
        end else if (sts.idx_lt_cnt) begin
          cmd.rd      = 1'b1;
          cmd.idx_inc = 1'b1;
          state_nxt   = S_DSH;
        end else begin
          state_nxt = S_DEND;
        end
      end
      // read upward past the removed entry, each beat written one place down
      S_DSH: begin
        cmd.mv_wb = 1'b1;
        if (sts.idx_lt_cnt) begin
          cmd.rd      = 1'b1;
          cmd.idx_inc = 1'b1;
        end else begin
          state_nxt = S_DEND;
        end
      end
      S_DEND: begin
        cmd.cnt_dec = 1'b1;
        state_nxt   = S_FIN;
      end
      S_SCAN: begin
        priority if (sts.rd_vld && sts.match) begin
          if (sts.act == bole_pkg::ACT_SEARCH) begin
            cmd.fnd_set = 1'b1;
            state_nxt   = S_FIN;
          end else begin
            cmd.idx_ld  = 1'b1;
            cmd.idx_sel = bole_pkg::IDX_NEXT;
            state_nxt   = S_RGET;
          end
        end else if (sts.idx_lt_cnt) begin
          cmd.rd      = 1'b1;
          cmd.idx_inc = 1'b1;
        end else begin
          if (sts.act == bole_pkg::ACT_DEL_KEY) begin
            cmd.st_ld = 1'b1;
            cmd.st    = bole_pkg::ST_NOKEY;
          end
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.res_ld = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> rtl/core/bounded_ordered_list_engine_unit.sv
`timescale 1ns / 1ps
// Top level of the bounded ordered list engine.
//
// Keeps an ordered list of up to CAPACITY signed 32-bit entries packed from
// position 0. Each beat on the in_ channel is one request (insert front/end/at,
// delete at, read, replace, search, delete by key, clear); each request gives
// exactly one result beat on the out_ channel with status, data, found flag,
// length and full/empty flags.
// Bad position, clear and full list requests need no memory walk. Shifts and
// searches walk the entry memory, which has a single write port and a
// registered read, one entry per cycle. One request is worked at a time;
// in_tready is high only while the controller is idle.
// The result sits in an output register, so a new request may be accepted
// while the last result still waits; if the receiver stalls, the next result
// is held inside until the output register frees.
// After reset the list is empty; entries hold no defined value until written.
module bounded_ordered_list_engine_unit #(
  parameter int CAPACITY = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  bole_pkg::in_bus_t  in_tdata,   // action[3:0], position[7:4], value[39:8]
  output logic               out_tvalid,
  input  logic               out_tready,
  output bole_pkg::out_bus_t out_tdata   // status[1:0], data[33:2], found[34],
                                         // length[38:35], full_flag[39],
                                         // empty_flag[40], zero pad[47:41]
);

  bole_pkg::cmd_t cmd;
  bole_pkg::sts_t sts;

  bole_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bole_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // one request at a time: no accept on the beat right after an accept
  a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted while previous one in progress");

  // the single write port is never claimed twice
  a_wr_port: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_val |-> !(cmd.mv_wb && sts.rd_vld))
    else $error("write port conflict");

  // memory walks stay inside the live part of the list
  a_rd_in_list: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd |-> sts.idx_lt_cnt)
    else $error("read beyond list length");

  a_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[39] && out_tdata[40]))
    else $error("result flagged full and empty");

endmodule

>>> test/bounded_ordered_list_engine_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the ordered list engine: directed corners, then random requests.
module bounded_ordered_list_engine_unit_tb;

  localparam int LIST_CAP    = 8;
  localparam int RANDOM_REQS = 1030;
  localparam int TAIL_REQS   = 120;
  localparam int CYCLE_LIMIT = 250000;
  localparam int LONG_HOLD   = 200;
  localparam int SETTLE      = 30;

  // action codes the block treats as no-ops
  localparam bole_pkg::action_t ACT_SPARE_LO = 4'd9;
  localparam bole_pkg::action_t ACT_SPARE_HI = 4'd15;

  typedef struct packed {
    bole_pkg::status_t status;
    bole_pkg::val_t    data;
    logic              found;
    bole_pkg::len_t    length;
    logic              full_flag;
    logic              empty_flag;
  } list_result_t;

  class list_scoreboard;
    bole_pkg::val_t entries [LIST_CAP];
    bole_pkg::len_t count;
    list_result_t   awaited_results [$];
    int             errors;
    int             checked;
    int             status_seen [4];
    int             search_hits;
    int             full_seen;
    int             empty_seen;

    function new();
      count = '0;
      errors = 0;
      checked = 0;
      search_hits = 0;
      full_seen = 0;
      empty_seen = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void insert_at(int p, bole_pkg::val_t v);
      for (int i = int'(count); i > p; i--) entries[i] = entries[i-1];
      entries[p] = v;
      count++;
    endfunction

    function bole_pkg::val_t remove_at(int p);
      bole_pkg::val_t gone;
      gone = entries[p];
      for (int i = p; i + 1 < count; i++) entries[i] = entries[i+1];
      count--;
      return gone;
    endfunction

    // next state of the list plus the result beat the request should give
    function list_result_t apply_request(bole_pkg::action_t a, bole_pkg::pos_t p,
                                         bole_pkg::val_t v);
      list_result_t r;
      r = '0;
      r.status = bole_pkg::ST_OK;
      case (a)
        bole_pkg::ACT_INS_FRONT, bole_pkg::ACT_INS_END, bole_pkg::ACT_INS_AT: begin
          if (count >= LIST_CAP) r.status = bole_pkg::ST_FULL;
          else if (a == bole_pkg::ACT_INS_FRONT) insert_at(0, v);
          else if (a == bole_pkg::ACT_INS_END) insert_at(int'(count), v);
          else if (p > count) r.status = bole_pkg::ST_BADPOS;
          else insert_at(int'(p), v);
        end
        bole_pkg::ACT_DEL_AT: begin
          if (p >= count) r.status = bole_pkg::ST_BADPOS;
          else r.data = remove_at(int'(p));
        end
        bole_pkg::ACT_READ: begin
          if (p >= count) r.status = bole_pkg::ST_BADPOS;
          else r.data = entries[p];
        end
        bole_pkg::ACT_REPLACE: begin
          if (p >= count) r.status = bole_pkg::ST_BADPOS;
          else entries[p] = v;
        end
        bole_pkg::ACT_SEARCH: begin
          for (int i = 0; i < count; i++)
            if (entries[i] == v) r.found = 1'b1;
        end
        bole_pkg::ACT_DEL_KEY: begin
          r.status = bole_pkg::ST_NOKEY;
          for (int i = 0; i < count; i++) begin
            if (r.status == bole_pkg::ST_NOKEY && entries[i] == v) begin
              r.data = remove_at(i);
              r.status = bole_pkg::ST_OK;
            end
          end
        end
        bole_pkg::ACT_CLEAR: count = '0;
        default: ;
      endcase
      r.length = count;
      r.full_flag = (count == LIST_CAP);
      r.empty_flag = (count == 0);
      return r;
    endfunction

    function void note_request(bole_pkg::action_t a, bole_pkg::pos_t p, bole_pkg::val_t v);
      list_result_t r;
      r = apply_request(a, p, v);
      status_seen[r.status]++;
      if (r.found) search_hits++;
      if (r.full_flag) full_seen++;
      if (r.empty_flag) empty_seen++;
      awaited_results.push_back(r);
    endfunction

    function void check_result(bole_pkg::out_bus_t bits);
      list_result_t got, want;
      got.status = bits[1:0];
      got.data = bits[33:2];
      got.found = bits[34];
      got.length = bits[38:35];
      got.full_flag = bits[39];
      got.empty_flag = bits[40];
      if (awaited_results.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing pending: st=%0d data=%0d fnd=%0b len=%0d",
                 $time, got.status, got.data, got.found, got.length);
      end else begin
        want = awaited_results.pop_front();
        checked++;
        if (got !== want) begin
          errors++;
          $display("%0t: beat %0d expected st=%0d data=%0d fnd=%0b len=%0d full=%0b empty=%0b",
                   $time, checked, want.status, want.data, want.found, want.length,
                   want.full_flag, want.empty_flag);
          $display("%0t: beat %0d actual   st=%0d data=%0d fnd=%0b len=%0d full=%0b empty=%0b",
                   $time, checked, got.status, got.data, got.found, got.length,
                   got.full_flag, got.empty_flag);
        end
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_tvalid;
  logic               in_tready;
  bole_pkg::in_bus_t  in_tdata;
  logic               out_tvalid;
  logic               out_tready;
  bole_pkg::out_bus_t out_tdata;

  list_scoreboard sb;
  bit quiet_tail = 1'b0;
  bit hold_out   = 1'b0;
  int cycle_count = 0;

  bounded_ordered_list_engine_unit #(.CAPACITY(LIST_CAP)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("bounded_ordered_list_engine_unit: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // receiver: short random stalls, one long hold-off on request
  initial begin : out_ready_gen
    int stall_left;
    stall_left = 0;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_out) begin
        hold_out = 1'b0;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0 && !quiet_tail && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 3);
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
      end
      @(posedge clk);
    end
  end

  task automatic send_request(input bole_pkg::action_t a, input bole_pkg::pos_t p,
                              input bole_pkg::val_t v);
    in_tdata <= {v, p, a};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(a, p, v);
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.awaited_results.size() != 0) @(posedge clk);
  endtask

  function automatic bole_pkg::val_t pick_value();
    if ($urandom_range(0, 9) < 4) return bole_pkg::val_t'($urandom_range(0, 15) - 8);
    return bole_pkg::val_t'($urandom);
  endfunction

  // grow biases toward inserts so the list swings between full and empty
  task automatic random_request(input bit grow);
    bole_pkg::action_t a;
    bole_pkg::pos_t    p;
    bole_pkg::val_t    v;
    int                n;
    int                roll;
    n = int'(sb.count);
    roll = $urandom_range(0, 99);
    if (roll < 50) begin
      if ($urandom_range(0, 49) < (grow ? 40 : 12)) begin
        case ($urandom_range(0, 2))
          0: a = bole_pkg::ACT_INS_FRONT;
          1: a = bole_pkg::ACT_INS_END;
          default: a = bole_pkg::ACT_INS_AT;
        endcase
      end else begin
        a = $urandom_range(0, 1) ? bole_pkg::ACT_DEL_AT : bole_pkg::ACT_DEL_KEY;
      end
    end else if (roll < 65) a = bole_pkg::ACT_READ;
    else if (roll < 77) a = bole_pkg::ACT_REPLACE;
    else if (roll < 93) a = bole_pkg::ACT_SEARCH;
    else if (roll < 94) a = bole_pkg::ACT_CLEAR;
    else a = bole_pkg::action_t'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
    if ($urandom_range(0, 9) < 8) p = bole_pkg::pos_t'($urandom_range(0, n));
    else p = bole_pkg::pos_t'($urandom_range(0, 15));
    if ((a == bole_pkg::ACT_SEARCH || a == bole_pkg::ACT_DEL_KEY) && n > 0 &&
        $urandom_range(0, 9) < 6)
      v = sb.entries[$urandom_range(0, n - 1)];
    else
      v = pick_value();
    send_request(a, p, v);
  endtask

  initial begin : main_seq
    bit grow;
    sb = new();
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty list corners
    send_request(bole_pkg::ACT_READ,    4'd0,  32'sd1);
    send_request(bole_pkg::ACT_DEL_AT,  4'd0,  32'sd1);
    send_request(bole_pkg::ACT_DEL_KEY, 4'd0,  32'sd7);
    send_request(bole_pkg::ACT_SEARCH,  4'd0,  32'sd7);
    send_request(bole_pkg::ACT_REPLACE, 4'd0,  32'sd3);
    send_request(bole_pkg::ACT_INS_AT,  4'd1,  32'sd3);
    // fill to capacity with extreme and duplicate values
    send_request(bole_pkg::ACT_INS_AT,    4'd0, 32'h8000_0000);
    send_request(bole_pkg::ACT_INS_FRONT, 4'd0, 32'h7fff_ffff);
    send_request(bole_pkg::ACT_INS_END,   4'd0, 32'hffff_ffff);
    send_request(bole_pkg::ACT_INS_AT,    4'd1, 32'sd5);
    send_request(bole_pkg::ACT_INS_END,   4'd0, 32'sd5);
    send_request(bole_pkg::ACT_INS_FRONT, 4'd0, 32'h5555_5555);
    send_request(bole_pkg::ACT_INS_END,   4'd0, 32'haaaa_aaaa);
    send_request(bole_pkg::ACT_INS_AT,    4'd7, 32'sd0);
    // full list: full wins over a bad position
    send_request(bole_pkg::ACT_INS_FRONT, 4'd0,  32'sd9);
    send_request(bole_pkg::ACT_INS_AT,    4'd15, 32'sd9);
    send_request(bole_pkg::ACT_READ,      4'd7,  32'sd0);
    send_request(bole_pkg::ACT_READ,      4'd8,  32'sd0);
    send_request(bole_pkg::ACT_REPLACE,   4'd15, 32'sd4);
    send_request(bole_pkg::ACT_REPLACE,   4'd7,  32'h8000_0000);
    send_request(bole_pkg::ACT_DEL_KEY,   4'd0,  32'sd5);
    send_request(bole_pkg::ACT_DEL_KEY,   4'd0,  32'sd1234);
    send_request(bole_pkg::ACT_DEL_AT,    4'd0,  32'sd0);
    send_request(ACT_SPARE_HI,            4'd15, 32'hffff_ffff);
    send_request(bole_pkg::ACT_CLEAR,     4'd0,  32'sd0);
    wait_drained();

    grow = 1'b1;
    for (int k = 0; k < RANDOM_REQS; k++) begin
      if (k % 60 == 0) grow = ~grow;
      if (k == 300) hold_out = 1'b1;
      if (k == 600) wait_drained();
      if (k == RANDOM_REQS - TAIL_REQS) quiet_tail = 1'b1;
      random_request(grow);
    end
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("%0d results checked: ok %0d, full %0d, bad position %0d, key missing %0d",
             sb.checked, sb.status_seen[bole_pkg::ST_OK], sb.status_seen[bole_pkg::ST_FULL],
             sb.status_seen[bole_pkg::ST_BADPOS], sb.status_seen[bole_pkg::ST_NOKEY]);
    $display("search hits %0d, results at full length %0d, at empty %0d",
             sb.search_hits, sb.full_seen, sb.empty_seen);
    if (sb.errors == 0 && sb.awaited_results.size() == 0) begin
      $display("bounded_ordered_list_engine_unit: match");
    end else begin
      $display("bounded_ordered_list_engine_unit: mismatch");
    end
    $finish;
  end

endmodule
